@@ src/brf_pkg.sv @@
// shared constants and types for the bitmap range fill and find block
`timescale 1ns / 1ps
`default_nettype none

package brf_pkg;

    // default geometry of the bitmap
    localparam int WORD_BITS_DEF = 64;
    localparam int MAX_BITS_DEF  = 4096;

    // field widths of the request and result
    localparam int INDEX_W = 13;
    localparam int POS_W   = 12;
    localparam int SIZE_W  = 13;

    // array size after reset
    localparam logic [SIZE_W-1:0] SIZE_RESET = 13'd4096;

    // request kinds
    localparam logic OP_FILL = 1'b0;
    localparam logic OP_FIND = 1'b1;

    // request control carried to the word unit
    typedef struct packed {
        logic op;
        logic bit_value;
    } req_ctl_t;

endpackage

`default_nettype wire

@@ src/brf_bitmap_mem.sv @@
// word memory of the bitmap with per-word valid bits and a registered read port
`timescale 1ns / 1ps
`default_nettype none

module brf_bitmap_mem #(
    parameter int WORD_BITS = brf_pkg::WORD_BITS_DEF,
    parameter int NUM_WORDS = 64,
    parameter int AW        = 6
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 we,
    input  wire logic [AW-1:0]        waddr,
    input  wire logic [WORD_BITS-1:0] wdata,
    input  wire logic                 re,
    input  wire logic [AW-1:0]        raddr,
    output logic      [WORD_BITS-1:0] rdata
);

    logic [WORD_BITS-1:0] mem [NUM_WORDS];
    logic [NUM_WORDS-1:0] valid_reg;
    logic [WORD_BITS-1:0] rd_word_reg;
    logic                 rd_valid_reg;

    // storage write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // valid bits, cleared at once by reset so the bitmap reads as zeros
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (we) begin
            valid_reg[waddr] <= 1'b1;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (re) begin
            rd_word_reg  <= mem[raddr];
            rd_valid_reg <= valid_reg[raddr];
        end
    end

    // a word never written reads as zero
    assign rdata = rd_valid_reg ? rd_word_reg : '0;

endmodule

`default_nettype wire

@@ src/brf_word_unit.sv @@
// shared word unit: range mask, fill update and first-match search on one word
`timescale 1ns / 1ps
`default_nettype none

module brf_word_unit #(
    parameter int WORD_BITS = brf_pkg::WORD_BITS_DEF,
    parameter int CMP_W     = 14,
    parameter int IDX_W     = 6
) (
    input  wire brf_pkg::req_ctl_t    ctl,
    input  wire logic [CMP_W-1:0]     first,
    input  wire logic [CMP_W-1:0]     limit,
    input  wire logic [CMP_W-1:0]     base,
    input  wire logic [WORD_BITS-1:0] word_in,
    output logic      [WORD_BITS-1:0] mask,
    output logic      [WORD_BITS-1:0] word_out,
    output logic                      hit,
    output logic      [IDX_W-1:0]     hit_idx
);

    localparam int OFF_W = $clog2(WORD_BITS + 1);
    localparam logic [CMP_W-1:0] WORD_SPAN = CMP_W'(WORD_BITS);
    localparam logic [OFF_W-1:0] WORD_OFF  = OFF_W'(WORD_BITS);

    logic [CMP_W-1:0]     lo_diff;
    logic [CMP_W-1:0]     hi_diff;
    logic [OFF_W-1:0]     lo_off;
    logic [OFF_W-1:0]     hi_off;
    logic [WORD_BITS-1:0] lo_ones;
    logic [WORD_BITS-1:0] hi_ones;
    logic [WORD_BITS-1:0] cand;

    // offsets of range start and end inside this word, clamped to the word
    always_comb begin
        lo_diff = first - base;
        hi_diff = limit - base;
        if (first <= base) begin
            lo_off = '0;
        end else if (lo_diff >= WORD_SPAN) begin
            lo_off = WORD_OFF;
        end else begin
            lo_off = lo_diff[OFF_W-1:0];
        end
        if (limit <= base) begin
            hi_off = '0;
        end else if (hi_diff >= WORD_SPAN) begin
            hi_off = WORD_OFF;
        end else begin
            hi_off = hi_diff[OFF_W-1:0];
        end
    end

    // bits of the word that lie inside the range
    always_comb begin
        lo_ones = (lo_off == WORD_OFF) ? '1 : ~({WORD_BITS{1'b1}} << lo_off);
        hi_ones = (hi_off == WORD_OFF) ? '1 : ~({WORD_BITS{1'b1}} << hi_off);
        mask    = hi_ones & ~lo_ones;
    end

    // fill update
    assign word_out = ctl.bit_value ? (word_in | mask) : (word_in & ~mask);

    // lowest in-range bit equal to the wanted value
    always_comb begin
        cand    = (ctl.bit_value ? word_in : ~word_in) & mask;
        hit     = |cand;
        hit_idx = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (cand[i]) begin
                hit_idx = IDX_W'(i);
            end
        end
    end

endmodule

`default_nettype wire

@@ src/bitmap_range_fill_and_find.sv @@
// top level: request sequencer, result register and configuration of the bitmap
`timescale 1ns / 1ps
`default_nettype none

// Keeps a bitmap of MAX_BITS bits, cleared by reset, in a memory of WORD_BITS-bit
// words. A fill request sets or clears the bits in [first_index, end_index); a find
// request returns the lowest position at or above first_index and below array_size
// whose bit equals bit_value. Each request yields one result. A request walks the
// memory one word per cycle from word 0 through the single read port and the shared
// word unit, stopping at the end of its range or, for a find, at the first hit; no
// new request is taken until its result has moved to the output register. A finished
// result waits in that output register, so the next request is taken while it is
// pending. array_size may be written only while idle.
module bitmap_range_fill_and_find #(
    parameter int WORD_BITS = brf_pkg::WORD_BITS_DEF,
    parameter int MAX_BITS  = brf_pkg::MAX_BITS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration: array_size
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [12:0] cfg_data,
    // request channel
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // first_index[12:0], end_index[25:13], bit_value[26]
    input  wire logic        s_tuser,   // op
    // result channel
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // position[11:0]
    output logic             m_tuser    // found
);

    localparam int NUM_WORDS = (MAX_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int CW        = $clog2(NUM_WORDS + 1);
    localparam int SPAN_W    = $clog2(NUM_WORDS * WORD_BITS + 1);
    localparam int CMP_W     = (SPAN_W > 14) ? SPAN_W : 14;
    localparam int IDX_W     = $clog2(WORD_BITS);
    localparam int POS_W     = brf_pkg::POS_W;
    localparam int INDEX_W   = brf_pkg::INDEX_W;

    localparam logic [CMP_W-1:0] MAX_LIMIT = CMP_W'(MAX_BITS);
    localparam logic [CMP_W-1:0] WORD_STEP = CMP_W'(WORD_BITS);
    localparam logic [CW-1:0]    WORD_CNT  = CW'(NUM_WORDS);

    // sequencer states
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]                 state_reg, state_next;
    logic [brf_pkg::SIZE_W-1:0] size_reg;
    brf_pkg::req_ctl_t          ctl_reg;
    logic [CMP_W-1:0]           first_reg;
    logic [CMP_W-1:0]           limit_reg, limit_next;
    logic [CW-1:0]              issue_cnt_reg, issue_cnt_next;
    logic [CMP_W-1:0]           issue_base_reg, issue_base_next;
    logic                       proc_valid_reg, proc_valid_next;
    logic [CMP_W-1:0]           proc_base_reg;
    logic [AW-1:0]              proc_addr_reg;
    logic                       res_found_reg, res_found_next;
    logic [POS_W-1:0]           res_pos_reg, res_pos_next;
    logic                       m_tvalid_reg;
    logic [POS_W-1:0]           m_pos_reg;
    logic                       m_found_reg;

    logic                       in_fire;
    logic                       issue_go;
    logic                       out_load;
    logic                       mem_we;
    logic [WORD_BITS-1:0]       rd_word;
    logic [WORD_BITS-1:0]       mask;
    logic [WORD_BITS-1:0]       new_word;
    logic                       hit;
    logic [IDX_W-1:0]           hit_idx;
    logic [CMP_W-1:0]           hit_pos;
    logic [CMP_W-1:0]           in_end;
    logic [CMP_W-1:0]           cur_size;

    // handshakes
    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_fire   = s_tvalid && s_tready;
    assign out_load  = (state_reg == ST_DONE) && (!m_tvalid_reg || m_tready);

    // configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg <= brf_pkg::SIZE_RESET;
        end else if (cfg_valid && cfg_ready) begin
            size_reg <= cfg_data;
        end
    end

    // range limit of a new request, clamped to the storage
    always_comb begin
        in_end   = CMP_W'(s_tdata[25:13]);
        cur_size = CMP_W'(size_reg);
        if (s_tuser == brf_pkg::OP_FILL) begin
            limit_next = (in_end > MAX_LIMIT) ? MAX_LIMIT : in_end;
        end else begin
            limit_next = (cur_size > MAX_LIMIT) ? MAX_LIMIT : cur_size;
        end
    end

    // request payload captured at the transaction
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            ctl_reg.op        <= s_tuser;
            ctl_reg.bit_value <= s_tdata[26];
            first_reg         <= CMP_W'(s_tdata[INDEX_W-1:0]);
            limit_reg         <= limit_next;
        end
    end

    // word issue and processing stage
    assign issue_go = (state_reg == ST_RUN) && (issue_cnt_reg != WORD_CNT)
                      && (issue_base_reg < limit_reg);
    assign hit_pos  = proc_base_reg + CMP_W'(hit_idx);
    assign mem_we   = (state_reg == ST_RUN) && proc_valid_reg
                      && (ctl_reg.op == brf_pkg::OP_FILL) && (|mask);

    always_comb begin
        state_next      = state_reg;
        issue_cnt_next  = issue_cnt_reg;
        issue_base_next = issue_base_reg;
        proc_valid_next = 1'b0;
        res_found_next  = res_found_reg;
        res_pos_next    = res_pos_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    state_next      = ST_RUN;
                    issue_cnt_next  = '0;
                    issue_base_next = '0;
                    res_found_next  = 1'b0;
                    res_pos_next    = '0;
                end
            end
            ST_RUN: begin
                if (issue_go) begin
                    issue_cnt_next  = issue_cnt_reg + CW'(1);
                    issue_base_next = issue_base_reg + WORD_STEP;
                end
                if (proc_valid_reg && (ctl_reg.op == brf_pkg::OP_FIND) && hit) begin
                    // first match ends the walk
                    res_found_next = 1'b1;
                    res_pos_next   = hit_pos[POS_W-1:0];
                    state_next     = ST_DONE;
                end else if (!issue_go && !proc_valid_reg) begin
                    state_next = ST_DONE;
                end else begin
                    proc_valid_next = issue_go;
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // sequencer control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            proc_valid_reg <= 1'b0;
            issue_cnt_reg  <= '0;
        end else begin
            state_reg      <= state_next;
            proc_valid_reg <= proc_valid_next;
            issue_cnt_reg  <= issue_cnt_next;
        end
    end

    // sequencer datapath registers
    always_ff @(posedge aclk) begin
        issue_base_reg <= issue_base_next;
        res_found_reg  <= res_found_next;
        res_pos_reg    <= res_pos_next;
        if (issue_go) begin
            proc_base_reg <= issue_base_reg;
            proc_addr_reg <= issue_cnt_reg[AW-1:0];
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_found_reg <= res_found_reg;
            m_pos_reg   <= res_pos_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_found_reg;
    assign m_tdata  = {{(16 - POS_W){1'b0}}, m_pos_reg};

    // bitmap storage
    brf_bitmap_mem #(
        .WORD_BITS (WORD_BITS),
        .NUM_WORDS (NUM_WORDS),
        .AW        (AW)
    ) u_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .we      (mem_we),
        .waddr   (proc_addr_reg),
        .wdata   (new_word),
        .re      (issue_go),
        .raddr   (issue_cnt_reg[AW-1:0]),
        .rdata   (rd_word)
    );

    // shared word unit
    brf_word_unit #(
        .WORD_BITS (WORD_BITS),
        .CMP_W     (CMP_W),
        .IDX_W     (IDX_W)
    ) u_word (
        .ctl      (ctl_reg),
        .first    (first_reg),
        .limit    (limit_reg),
        .base     (proc_base_reg),
        .word_in  (rd_word),
        .mask     (mask),
        .word_out (new_word),
        .hit      (hit),
        .hit_idx  (hit_idx)
    );

    // an accepted request always starts a walk
    a_accept_runs: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire |=> (state_reg == ST_RUN))
        else $error("request accepted without starting a walk");

    // the word counter never passes the end of the memory
    a_issue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        issue_cnt_reg <= WORD_CNT)
        else $error("word counter beyond the memory");

    // a fill never reports a match
    a_fill_not_found: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_DONE) && (ctl_reg.op == brf_pkg::OP_FILL)) |-> !res_found_reg)
        else $error("fill request reported a match");

endmodule

`default_nettype wire
